/* rtl/dale_pkg.sv */
// Shared constants and codes for the dual array list engine.
`timescale 1ns / 1ps
package dale_pkg;
    localparam int DEPTH = 32;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = CW + 1;
    localparam int AW    = IW + 1;
    localparam int CMPW  = ((CW > 6) ? CW : 6) + 1;
    localparam int DW    = 32;

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_TRAVERSE = 3'd1;
    localparam logic [2:0] ACT_INSERT   = 3'd2;
    localparam logic [2:0] ACT_DELETE   = 3'd3;
    localparam logic [2:0] ACT_SEARCH   = 3'd4;
    localparam logic [2:0] ACT_SORT     = 3'd5;
    localparam logic [2:0] ACT_CONCAT   = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_POS   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_ctl;
endpackage

/* rtl/dale_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
module dale_ram #(
    parameter int P_AW = 6,
    parameter int P_DW = 32
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [P_AW-1:0] i_waddr,
    input  logic [P_DW-1:0] i_wdata,
    input  logic            i_re,
    input  logic [P_AW-1:0] i_raddr,
    output logic [P_DW-1:0] o_rdata
);
    logic [P_DW-1:0] r_mem [2**P_AW];
    logic [P_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/dual_array_list_engine_unit.sv */
// Top level of the dual array list engine: command sequencer around the array RAM.
`timescale 1ns / 1ps
// Both arrays live in one RAM with one write and one read port; each step of an
// action makes at most one RAM access. Append writes the item, traverse and
// concatenate read and emit each element (emits wait for output stalls), insert
// and delete shift the elements past the position and then emit the list, search
// reads and compares each element, and sort runs compare-swap passes (one read,
// then one compare) before the emit. A new item is taken only when the previous
// action has pushed its last result into the output register.
module dual_array_list_engine_unit
    import dale_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic        i_which_array,
    input  logic [5:0]  i_position,
    input  logic [31:0] i_item_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_element_value,
    output logic [5:0]  o_element_index,
    output logic [2:0]  o_status,
    output logic        o_last_item
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_WR = 4'd3;
    localparam logic [3:0] S_DEL_RD = 4'd4;
    localparam logic [3:0] S_DEL_WR = 4'd5;
    localparam logic [3:0] S_ERD    = 4'd6;
    localparam logic [3:0] S_EOUT   = 4'd7;
    localparam logic [3:0] S_SRD    = 4'd8;
    localparam logic [3:0] S_SCMP   = 4'd9;
    localparam logic [3:0] S_SEND   = 4'd10;
    localparam logic [3:0] S_SI     = 4'd11;
    localparam logic [3:0] S_SIL    = 4'd12;
    localparam logic [3:0] S_SJ     = 4'd13;
    localparam logic [3:0] S_SJC    = 4'd14;

    logic [3:0]    r_st, n_st;
    logic [2:0]    r_act;
    logic          r_sel;
    logic [5:0]    r_pos;
    logic [DW-1:0] r_val;
    logic [CW-1:0] r_ca, n_ca, r_cb, n_cb;
    logic [XW-1:0] r_i, n_i, r_n, n_n;
    logic [CW-1:0] r_j, n_j;
    logic          r_cat, n_cat;
    logic [DW-1:0] r_cur, n_cur;
    logic          r_pv, n_pv;
    logic [5:0]    r_pidx, n_pidx;

    logic          r_ov;
    logic [DW-1:0] r_oval;
    logic [5:0]    r_oidx;
    logic [2:0]    r_ost;
    logic          r_olast;

    logic          w_push, w_free;
    logic [DW-1:0] w_pval;
    logic [5:0]    w_pidx;
    logic [2:0]    w_pst;
    logic          w_plast;

    t_ram_ctl      w_ram;
    logic [DW-1:0] w_rdata;

    logic [CW-1:0]   w_n;
    logic [CMPW-1:0] w_posx, w_nx, w_pm1;
    logic [XW-1:0]   w_off;
    logic [31:0]     w_iw, w_nw;

    dale_ram #(.P_AW(AW), .P_DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    assign w_free = !r_ov || i_ready;
    assign w_n    = r_sel ? r_cb : r_ca;
    assign w_posx = CMPW'(r_pos);
    assign w_nx   = CMPW'(w_n);
    assign w_pm1  = w_posx - CMPW'(1);
    assign w_off  = r_i - XW'(r_ca);
    assign w_iw   = 32'(r_i);
    assign w_nw   = 32'(w_n);

    always_comb begin
        n_st = r_st; n_ca = r_ca; n_cb = r_cb; n_i = r_i; n_n = r_n; n_j = r_j;
        n_cat = r_cat; n_cur = r_cur; n_pv = r_pv; n_pidx = r_pidx;
        w_push = 1'b0; w_pval = '0; w_pidx = '0; w_pst = ST_OK; w_plast = 1'b1;
        w_ram = '0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_st = S_DISP;
                end
            end
            S_DISP: begin
                if (w_free) begin
                    n_i = '0; n_cat = 1'b0; n_n = XW'(w_n); n_pv = 1'b0;
                    case (r_act)
                        ACT_APPEND: begin
                            w_push = 1'b1; n_st = S_IDLE;
                            if (w_n == CW'(DEPTH)) begin
                                w_pst = ST_FULL;
                            end else begin
                                w_ram.we = 1'b1;
                                w_ram.waddr = {r_sel, w_n[IW-1:0]};
                                w_ram.wdata = r_val;
                                w_pval = r_val; w_pidx = w_nw[5:0];
                                if (r_sel) n_cb = r_cb + CW'(1);
                                else n_ca = r_ca + CW'(1);
                            end
                        end
                        ACT_TRAVERSE: begin
                            if (w_n == '0) begin
                                w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                            end else n_st = S_ERD;
                        end
                        ACT_INSERT: begin
                            if (w_n == CW'(DEPTH)) begin
                                w_push = 1'b1; w_pst = ST_FULL; n_st = S_IDLE;
                            end else if (r_pos == '0 || w_posx > w_nx + CMPW'(1)) begin
                                w_push = 1'b1; w_pst = ST_BAD_POS; n_st = S_IDLE;
                            end else begin
                                n_i = XW'(w_n); n_st = S_INS_RD;
                            end
                        end
                        ACT_DELETE: begin
                            if (w_n == '0) begin
                                w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                            end else if (r_pos == '0 || w_posx > w_nx) begin
                                w_push = 1'b1; w_pst = ST_BAD_POS; n_st = S_IDLE;
                            end else begin
                                n_i = XW'(w_pm1); n_st = S_DEL_RD;
                            end
                        end
                        ACT_SEARCH: begin
                            if (w_n == '0) begin
                                w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                            end else n_st = S_SRD;
                        end
                        ACT_SORT: begin
                            if (w_n == '0) begin
                                w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                            end else n_st = S_SI;
                        end
                        ACT_CONCAT: begin
                            if (r_ca == '0 && r_cb == '0) begin
                                w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                            end else begin
                                n_cat = 1'b1; n_n = XW'(r_ca) + XW'(r_cb); n_st = S_ERD;
                            end
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: begin
                if (CMPW'(r_i) > w_pm1) begin
                    w_ram.re = 1'b1;
                    w_ram.raddr = {r_sel, IW'(r_i - XW'(1))};
                    n_st = S_INS_WR;
                end else begin
                    w_ram.we = 1'b1;
                    w_ram.waddr = {r_sel, w_pm1[IW-1:0]};
                    w_ram.wdata = r_val;
                    if (r_sel) n_cb = r_cb + CW'(1);
                    else n_ca = r_ca + CW'(1);
                    n_n = XW'(w_n) + XW'(1); n_i = '0; n_st = S_ERD;
                end
            end
            S_INS_WR: begin
                w_ram.we = 1'b1;
                w_ram.waddr = {r_sel, r_i[IW-1:0]};
                w_ram.wdata = w_rdata;
                n_i = r_i - XW'(1); n_st = S_INS_RD;
            end
            S_DEL_RD: begin
                if (r_i + XW'(1) < XW'(w_n)) begin
                    w_ram.re = 1'b1;
                    w_ram.raddr = {r_sel, IW'(r_i + XW'(1))};
                    n_st = S_DEL_WR;
                end else if (w_free) begin
                    if (r_sel) n_cb = r_cb - CW'(1);
                    else n_ca = r_ca - CW'(1);
                    if (w_n == CW'(1)) begin
                        w_push = 1'b1; w_pst = ST_EMPTY; n_st = S_IDLE;
                    end else begin
                        n_n = XW'(w_n) - XW'(1); n_i = '0; n_st = S_ERD;
                    end
                end
            end
            S_DEL_WR: begin
                w_ram.we = 1'b1;
                w_ram.waddr = {r_sel, r_i[IW-1:0]};
                w_ram.wdata = w_rdata;
                n_i = r_i + XW'(1); n_st = S_DEL_RD;
            end
            S_ERD: begin
                w_ram.re = 1'b1;
                if (r_cat && r_i >= XW'(r_ca)) w_ram.raddr = {1'b1, w_off[IW-1:0]};
                else if (r_cat) w_ram.raddr = {1'b0, r_i[IW-1:0]};
                else w_ram.raddr = {r_sel, r_i[IW-1:0]};
                n_st = S_EOUT;
            end
            S_EOUT: begin
                if (w_free) begin
                    w_push = 1'b1; w_pval = w_rdata; w_pidx = w_iw[5:0];
                    w_plast = (r_i == r_n - XW'(1));
                    if (w_plast) n_st = S_IDLE;
                    else begin
                        n_i = r_i + XW'(1); n_st = S_ERD;
                    end
                end
            end
            S_SRD: begin
                if (r_i < XW'(w_n)) begin
                    w_ram.re = 1'b1;
                    w_ram.raddr = {r_sel, r_i[IW-1:0]};
                    n_st = S_SCMP;
                end else n_st = S_SEND;
            end
            S_SCMP: begin
                if (w_rdata != r_val) begin
                    n_i = r_i + XW'(1); n_st = S_SRD;
                end else if (!r_pv || w_free) begin
                    if (r_pv) begin
                        w_push = 1'b1; w_pval = r_val; w_pidx = r_pidx; w_plast = 1'b0;
                    end
                    n_pv = 1'b1; n_pidx = w_iw[5:0];
                    n_i = r_i + XW'(1); n_st = S_SRD;
                end
            end
            S_SEND: begin
                if (w_free) begin
                    w_push = 1'b1; n_st = S_IDLE;
                    if (r_pv) begin
                        w_pval = r_val; w_pidx = r_pidx;
                    end else w_pst = ST_NOT_FOUND;
                end
            end
            S_SI: begin
                if (r_i < XW'(w_n)) begin
                    w_ram.re = 1'b1;
                    w_ram.raddr = {r_sel, r_i[IW-1:0]};
                    n_st = S_SIL;
                end else begin
                    n_i = '0; n_st = S_ERD;
                end
            end
            S_SIL: begin
                n_cur = w_rdata; n_j = CW'(r_i) + CW'(1); n_st = S_SJ;
            end
            S_SJ: begin
                if (r_j < w_n) begin
                    w_ram.re = 1'b1;
                    w_ram.raddr = {r_sel, r_j[IW-1:0]};
                    n_st = S_SJC;
                end else begin
                    w_ram.we = 1'b1;
                    w_ram.waddr = {r_sel, r_i[IW-1:0]};
                    w_ram.wdata = r_cur;
                    n_i = r_i + XW'(1); n_st = S_SI;
                end
            end
            S_SJC: begin
                if ($signed(w_rdata) < $signed(r_cur)) begin
                    w_ram.we = 1'b1;
                    w_ram.waddr = {r_sel, r_j[IW-1:0]};
                    w_ram.wdata = r_cur;
                    n_cur = w_rdata;
                end
                n_j = r_j + CW'(1); n_st = S_SJ;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ca <= '0; r_cb <= '0; r_ov <= 1'b0; r_pv <= 1'b0;
            r_i <= '0; r_n <= '0; r_j <= '0; r_cat <= 1'b0;
        end else begin
            r_st <= n_st; r_ca <= n_ca; r_cb <= n_cb; r_pv <= n_pv;
            r_i <= n_i; r_n <= n_n; r_j <= n_j; r_cat <= n_cat;
            if (w_push) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_pidx <= n_pidx;
        if (r_st == S_IDLE && i_valid) begin
            r_act <= i_action; r_sel <= i_which_array;
            r_pos <= i_position; r_val <= i_item_value;
        end
        if (w_push) begin
            r_oval <= w_pval; r_oidx <= w_pidx; r_ost <= w_pst; r_olast <= w_plast;
        end
    end

    assign o_ready         = (r_st == S_IDLE);
    assign o_valid         = r_ov;
    assign o_element_value = r_oval;
    assign o_element_index = r_oidx;
    assign o_status        = r_ost;
    assign o_last_item     = r_olast;

    a_cnt_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ca <= CW'(DEPTH)) else $error("count A above depth");
    a_cnt_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cb <= CW'(DEPTH)) else $error("count B above depth");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_free) else $error("result pushed over a pending item");
    a_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram.we && w_ram.re && w_ram.waddr == w_ram.raddr))
        else $error("read and write to the same entry");
endmodule

/* tb/dual_array_list_engine_unit_test.sv */
// Self-checking testbench for the dual array list engine: directed table plus random actions.
`timescale 1ns / 1ps
module dual_array_list_engine_unit_test;
    import dale_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  index;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef struct {
        logic [2:0]  action;
        logic        which;
        logic [5:0]  position;
        logic [31:0] value;
        bit          has_fixed;
        t_result     fixed;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = '0;
    logic        i_which_array = 1'b0;
    logic [5:0]  i_position = '0;
    logic [31:0] i_item_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_element_value;
    logic [5:0]  o_element_index;
    logic [2:0]  o_status;
    logic        o_last_item;

    dual_array_list_engine_unit dut (.*);

    always #4 i_clk = ~i_clk;

    logic [31:0] model_arr [2][DEPTH];
    int          model_cnt [2];
    t_result     expected_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    longint      cycle_count = 0;

    function automatic t_result mk(logic [31:0] v, logic [5:0] x, logic [2:0] s, logic l);
        t_result r;
        r.value = v; r.index = x; r.status = s; r.last = l;
        return r;
    endfunction

    function automatic void emit_list(int w, int offset, bit final_group);
        for (int i = 0; i < model_cnt[w]; i++)
            expected_results.push_back(mk(model_arr[w][i], 6'(offset + i), ST_OK,
                final_group && (i == model_cnt[w] - 1)));
    endfunction

    function automatic void predict_action(logic [2:0] act, logic which, logic [5:0] pos,
                                           logic [31:0] val);
        int w;
        int n;
        int hits;
        logic [31:0] t;
        w = which;
        n = model_cnt[w];
        hits = 0;
        case (act)
            ACT_APPEND: begin
                if (n >= DEPTH) begin
                    expected_results.push_back(mk(0, 0, ST_FULL, 1));
                end else begin
                    model_arr[w][n] = val;
                    model_cnt[w] = n + 1;
                    expected_results.push_back(mk(val, 6'(n), ST_OK, 1));
                end
            end
            ACT_TRAVERSE: begin
                if (n == 0) expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                else emit_list(w, 0, 1);
            end
            ACT_INSERT: begin
                if (n >= DEPTH) begin
                    expected_results.push_back(mk(0, 0, ST_FULL, 1));
                end else if (pos < 1 || pos > n + 1) begin
                    expected_results.push_back(mk(0, 0, ST_BAD_POS, 1));
                end else begin
                    for (int i = n; i > pos - 1; i--) model_arr[w][i] = model_arr[w][i-1];
                    model_arr[w][pos-1] = val;
                    model_cnt[w] = n + 1;
                    emit_list(w, 0, 1);
                end
            end
            ACT_DELETE: begin
                if (n == 0) begin
                    expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                end else if (pos < 1 || pos > n) begin
                    expected_results.push_back(mk(0, 0, ST_BAD_POS, 1));
                end else begin
                    for (int i = pos - 1; i + 1 < n; i++) model_arr[w][i] = model_arr[w][i+1];
                    model_cnt[w] = n - 1;
                    if (n == 1) expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                    else emit_list(w, 0, 1);
                end
            end
            ACT_SEARCH: begin
                if (n == 0) begin
                    expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                end else begin
                    for (int i = 0; i < n; i++)
                        if (model_arr[w][i] == val) begin
                            expected_results.push_back(mk(val, 6'(i), ST_OK, 0));
                            hits++;
                        end
                    if (hits == 0) expected_results.push_back(mk(0, 0, ST_NOT_FOUND, 1));
                    else expected_results[$].last = 1'b1;
                end
            end
            ACT_SORT: begin
                if (n == 0) begin
                    expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                end else begin
                    for (int i = 0; i < n; i++)
                        for (int j = i + 1; j < n; j++)
                            if ($signed(model_arr[w][j]) < $signed(model_arr[w][i])) begin
                                t = model_arr[w][i];
                                model_arr[w][i] = model_arr[w][j];
                                model_arr[w][j] = t;
                            end
                    emit_list(w, 0, 1);
                end
            end
            ACT_CONCAT: begin
                if (model_cnt[0] == 0 && model_cnt[1] == 0) begin
                    expected_results.push_back(mk(0, 0, ST_EMPTY, 1));
                end else begin
                    emit_list(0, 0, model_cnt[1] == 0);
                    emit_list(1, model_cnt[0], 1);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(t_stim s);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_action <= s.action;
        i_which_array <= s.which;
        i_position <= s.position;
        i_item_value <= s.value;
        i_valid <= 1'b1;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (s.has_fixed) begin
            predict_action(s.action, s.which, s.position, s.value);
            expected_results[$] = s.fixed;
        end else begin
            predict_action(s.action, s.which, s.position, s.value);
        end
        items_sent++;
    endtask

    function automatic t_stim row(logic [2:0] a, logic w, logic [5:0] p, logic [31:0] v);
        t_stim s;
        s.action = a; s.which = w; s.position = p; s.value = v;
        s.has_fixed = 0; s.fixed = '0;
        return s;
    endfunction

    function automatic t_stim row_fixed(logic [2:0] a, logic w, logic [5:0] p, logic [31:0] v,
                                        t_result r);
        t_stim s;
        s = row(a, w, p, v);
        s.has_fixed = 1; s.fixed = r;
        return s;
    endfunction

    function automatic t_stim random_item();
        t_stim s;
        int w;
        int n;
        int r;
        w = $urandom_range(1);
        n = model_cnt[w];
        r = $urandom_range(99);
        s = row(ACT_APPEND, 1'(w), 6'($urandom), $urandom);
        if ($urandom_range(3) == 0) s.value = 32'($urandom_range(5)) - 32'd2;
        if (r < 30) s.action = ACT_APPEND;
        else if (r < 40) s.action = ACT_TRAVERSE;
        else if (r < 55) s.action = ACT_INSERT;
        else if (r < 70) s.action = ACT_DELETE;
        else if (r < 82) s.action = ACT_SEARCH;
        else if (r < 89) s.action = ACT_SORT;
        else if (r < 96) s.action = ACT_CONCAT;
        else s.action = 3'd7;
        if ((s.action == ACT_INSERT || s.action == ACT_DELETE) && $urandom_range(9) > 1)
            s.position = 6'($urandom_range(n + 1, 1));
        if (s.action == ACT_SEARCH && n > 0 && $urandom_range(1))
            s.value = model_arr[w][$urandom_range(n - 1)];
        return s;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result: value %h index %0d status %0d last %0d",
                             o_element_value, o_element_index, o_status, o_last_item);
            end else begin
                if (expected_results[0] !== {o_element_value, o_element_index, o_status,
                                             o_last_item}) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected v %h i %0d s %0d l %0d, got v %h i %0d s %0d l %0d",
                                 expected_results[0].value, expected_results[0].index,
                                 expected_results[0].status, expected_results[0].last,
                                 o_element_value, o_element_index, o_status, o_last_item);
                end
                void'(expected_results.pop_front());
            end
        end
        if (recv_hold) i_ready <= 1'b0;
        else i_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (cycle_count > 2000000) begin
            $display("dual_array_list_engine_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_stim dir [$];
        int phase_idle [4] = '{0, 53, 0, 33};
        int phase_stall [4] = '{0, 0, 53, 33};
        int done_wait;
        model_cnt[0] = 0;
        model_cnt[1] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir.push_back(row_fixed(ACT_TRAVERSE, 0, 0, 0, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row_fixed(ACT_DELETE, 1, 1, 0, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row_fixed(ACT_SEARCH, 0, 0, 5, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row_fixed(ACT_SORT, 1, 0, 0, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row_fixed(ACT_CONCAT, 0, 0, 0, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row_fixed(ACT_APPEND, 0, 63, 32'h7fffffff, mk(32'h7fffffff, 0, ST_OK, 1)));
        dir.push_back(row_fixed(ACT_APPEND, 0, 0, 32'h80000000, mk(32'h80000000, 1, ST_OK, 1)));
        dir.push_back(row_fixed(ACT_INSERT, 0, 0, 1, mk(0, 0, ST_BAD_POS, 1)));
        dir.push_back(row_fixed(ACT_INSERT, 0, 63, 1, mk(0, 0, ST_BAD_POS, 1)));
        dir.push_back(row(ACT_INSERT, 0, 1, 32'hffffffff));
        dir.push_back(row(ACT_INSERT, 0, 4, 0));
        dir.push_back(row_fixed(ACT_DELETE, 0, 5, 0, mk(0, 0, ST_BAD_POS, 1)));
        dir.push_back(row(ACT_DELETE, 0, 2, 0));
        dir.push_back(row_fixed(ACT_SEARCH, 0, 0, 12345, mk(0, 0, ST_NOT_FOUND, 1)));
        dir.push_back(row(ACT_SEARCH, 0, 0, 32'hffffffff));
        dir.push_back(row(ACT_SORT, 0, 0, 0));
        dir.push_back(row_fixed(ACT_APPEND, 1, 0, 7, mk(7, 0, ST_OK, 1)));
        dir.push_back(row(ACT_CONCAT, 1, 0, 0));
        dir.push_back(row_fixed(ACT_DELETE, 1, 1, 0, mk(0, 0, ST_EMPTY, 1)));
        dir.push_back(row(ACT_CONCAT, 0, 0, 0));
        dir.push_back(row(3'd7, 1, 63, 32'hffffffff));
        foreach (dir[k]) send_item(dir[k]);
        // fill B to capacity and hit full-array cases
        for (int k = 0; k < DEPTH; k++) send_item(row(ACT_APPEND, 1, 0, $urandom));
        send_item(row_fixed(ACT_APPEND, 1, 0, 1, mk(0, 0, ST_FULL, 1)));
        send_item(row_fixed(ACT_INSERT, 1, 1, 1, mk(0, 0, ST_FULL, 1)));
        send_item(row(ACT_SORT, 1, 0, 0));
        send_item(row(ACT_CONCAT, 0, 0, 0));

        // long receiver hold while items keep coming
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_item(row(ACT_APPEND, 0, 0, $urandom));
        join

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int k = 0; k < 25; k++) send_item(random_item());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 10; k++) send_item(random_item());
        i_valid <= 1'b0;

        done_wait = 0;
        while (expected_results.size() > 0 && done_wait < 200000) begin
            @(posedge i_clk);
            done_wait++;
        end
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items covering all actions, full/empty/bad-position cases,",
                 items_sent);
        $display("and idle/stall phases; %0d results checked.", results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("dual_array_list_engine_unit verification clean");
        else
            $display("dual_array_list_engine_unit verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/dale_pkg.sv
rtl/dale_ram.sv
rtl/dual_array_list_engine_unit.sv
tb/dual_array_list_engine_unit_test.sv
